// ===== rtl/chunked_transfer_decoder_macros.svh =====
// Assertion helpers for the chunked transfer decoder.
// Both expect clk and rst_n to be visible where they are used.
`ifndef CHUNKED_TRANSFER_DECODER_MACROS_SVH
`define CHUNKED_TRANSFER_DECODER_MACROS_SVH

// same-cycle implication
`define CTD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctd: same-cycle check failed");

// next-cycle implication
`define CTD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctd: next-cycle check failed");

`endif

// ===== rtl/ctd_pkg.sv =====
package ctd_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // what the current size line has held so far
    typedef enum logic [1:0] {
        KIND_EMPTY  = 2'd0,
        KIND_ONE_CR = 2'd1,
        KIND_OTHER  = 2'd2
    } line_kind_t;

    // where the size parser is within the hex number
    typedef enum logic [1:0] {
        PHASE_BLANKS = 2'd0,
        PHASE_DIGITS = 2'd1,
        PHASE_CLOSED = 2'd2
    } num_phase_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
               (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
            r = {1'b1, 4'(c - "0")};
        else if (c >= "a" && c <= "f")
            r = {1'b1, 4'(c - "a" + 8'd10)};
        else if (c >= "A" && c <= "F")
            r = {1'b1, 4'(c - "A" + 8'd10)};
        return r;
    endfunction

endpackage

// ===== rtl/chunked_transfer_decoder.sv =====
// channel | signals                                      | beat taken when
// --------+----------------------------------------------+---------------------------
// input   | in_valid, in_ready, in_byte, is_last         | in_valid && in_ready
// output  | out_valid, out_ready, payload_byte, has_byte, | out_valid && out_ready
//         | message_end                                  |
//
// One input beat per cycle while in_ready is high; the result is registered on the
// output register in the cycle after the beat is taken. Rate is set by the parser
// state update and the shift-add into the chunk count, both combinational.
// in_ready stays high while the output register is empty or being drained.
// Asynchronous reset puts the parser in size-line mode with a zero count.
`include "chunked_transfer_decoder_macros.svh"

module chunked_transfer_decoder
    import ctd_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       has_byte,
    output logic       message_end
);

    typedef enum logic [1:0] {
        MODE_SIZE = 2'd0,
        MODE_DATA = 2'd1,
        MODE_SKIP = 2'd2,
        MODE_DONE = 2'd3
    } mode_t;

    mode_t                  mode_reg, mode_next;
    line_kind_t             kind_reg, kind_next;
    num_phase_t             phase_reg, phase_next;
    logic                   seen_reg, seen_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       has_reg;
    logic       end_reg;

    logic       in_fire;
    logic       res_has;
    logic       res_valid;
    logic [4:0] hex;
    logic       count_sat;
    logic [COUNT_WIDTH-1:0] count_acc;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign hex       = hex_digit(in_byte);
    assign count_sat = |count_reg[COUNT_WIDTH-1 -: 4];
    assign count_acc = count_sat ? {COUNT_WIDTH{1'b1}}
                                 : {count_reg[COUNT_WIDTH-5:0], hex[3:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        phase_next = phase_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        res_has    = 1'b0;

        unique case (mode_reg)
            MODE_SIZE:
            begin
                if (in_byte == CHAR_LF)
                begin
                    if (kind_reg == KIND_OTHER)
                    begin
                        if (!seen_reg || count_reg == '0)
                            mode_next = MODE_DONE;
                        else
                        begin
                            mode_next  = MODE_DATA;
                            kind_next  = KIND_EMPTY;
                            phase_next = PHASE_BLANKS;
                            seen_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        // empty or lone-CR line: skip it
                        kind_next  = KIND_EMPTY;
                        phase_next = PHASE_BLANKS;
                        seen_next  = 1'b0;
                        count_next = '0;
                    end
                end
                else
                begin
                    kind_next = (kind_reg == KIND_EMPTY && in_byte == CHAR_CR) ?
                                KIND_ONE_CR : KIND_OTHER;
                    case (phase_reg)
                        PHASE_BLANKS:
                        begin
                            if (!is_blank(in_byte))
                            begin
                                if (hex[4])
                                begin
                                    phase_next = PHASE_DIGITS;
                                    seen_next  = 1'b1;
                                    count_next = count_acc;
                                end
                                else
                                    phase_next = PHASE_CLOSED;
                            end
                        end
                        PHASE_DIGITS:
                        begin
                            if (hex[4])
                            begin
                                seen_next  = 1'b1;
                                count_next = count_acc;
                            end
                            else
                                phase_next = PHASE_CLOSED;
                        end
                        default: ;
                    endcase
                end
            end
            MODE_DATA:
            begin
                res_has    = 1'b1;
                count_next = count_reg - COUNT_WIDTH'(1);
                if (count_reg == COUNT_WIDTH'(1))
                    mode_next = MODE_SKIP;
            end
            MODE_SKIP:
            begin
                if (in_byte == CHAR_LF)
                begin
                    mode_next  = MODE_SIZE;
                    kind_next  = KIND_EMPTY;
                    phase_next = PHASE_BLANKS;
                    seen_next  = 1'b0;
                    count_next = '0;
                end
            end
            MODE_DONE: ;
            default: ;
        endcase

        // last beat of the message restarts the parser
        if (is_last)
        begin
            mode_next  = MODE_SIZE;
            kind_next  = KIND_EMPTY;
            phase_next = PHASE_BLANKS;
            seen_next  = 1'b0;
            count_next = '0;
        end
    end

    assign res_valid = res_has || is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SIZE;
            kind_reg      <= KIND_EMPTY;
            phase_reg     <= PHASE_BLANKS;
            seen_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            byte_reg      <= 8'd0;
            has_reg       <= 1'b0;
            end_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire && res_valid)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (in_fire)
            begin
                mode_reg  <= mode_next;
                kind_reg  <= kind_next;
                phase_reg <= phase_next;
                seen_reg  <= seen_next;
                count_reg <= count_next;
                if (res_valid)
                begin
                    byte_reg <= res_has ? in_byte : 8'd0;
                    has_reg  <= res_has;
                    end_reg  <= is_last;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = byte_reg;
    assign has_byte     = has_reg;
    assign message_end  = end_reg;

    `CTD_ASSERT_NXT(a_data_gives_byte, in_fire && mode_reg == MODE_DATA, out_valid && has_byte)
    `CTD_ASSERT_NXT(a_last_restarts, in_fire && is_last,
        mode_reg == MODE_SIZE && count_reg == '0 && out_valid && message_end)
    `CTD_ASSERT_IMP(a_result_has_cause, out_valid && !has_byte, message_end)
    `CTD_ASSERT_IMP(a_data_count_live, mode_reg == MODE_DATA, count_reg != '0)
    `CTD_ASSERT_IMP(a_idle_byte_zero, out_valid && !has_byte, payload_byte == 8'd0)

endmodule
